>>> design/wunu_pkg.sv
// ----------------------------------------------------------------------------
// wunu_pkg
// Shared constants, command codes, cell payload type and bit-level helper
// functions for the unary numeric unit.
// ----------------------------------------------------------------------------
package wunu_pkg;

    // one cell per root digit of the widest format (mantissa bits + 2)
    localparam int NUM_CELLS = 54;
    localparam int RAD_W     = 2 * NUM_CELLS;
    localparam int Q_W       = NUM_CELLS;
    localparam int REM_W     = Q_W + 3;

    localparam logic [4:0] CMD_I32_CLZ    = 5'd0;
    localparam logic [4:0] CMD_I32_CTZ    = 5'd1;
    localparam logic [4:0] CMD_I32_POPCNT = 5'd2;
    localparam logic [4:0] CMD_I64_CLZ    = 5'd3;
    localparam logic [4:0] CMD_I64_CTZ    = 5'd4;
    localparam logic [4:0] CMD_I64_POPCNT = 5'd5;
    localparam logic [4:0] CMD_F32_ABS    = 5'd6;
    localparam logic [4:0] CMD_F32_NEG    = 5'd7;
    localparam logic [4:0] CMD_F32_CEIL   = 5'd8;
    localparam logic [4:0] CMD_F32_FLOOR  = 5'd9;
    localparam logic [4:0] CMD_F32_TRUNC  = 5'd10;
    localparam logic [4:0] CMD_F32_NEAR   = 5'd11;
    localparam logic [4:0] CMD_F32_SQRT   = 5'd12;
    localparam logic [4:0] CMD_F64_ABS    = 5'd13;
    localparam logic [4:0] CMD_F64_NEG    = 5'd14;
    localparam logic [4:0] CMD_F64_CEIL   = 5'd15;
    localparam logic [4:0] CMD_F64_FLOOR  = 5'd16;
    localparam logic [4:0] CMD_F64_TRUNC  = 5'd17;
    localparam logic [4:0] CMD_F64_NEAR   = 5'd18;
    localparam logic [4:0] CMD_F64_SQRT   = 5'd19;

    localparam logic [1:0] RND_CEIL  = 2'd0;
    localparam logic [1:0] RND_FLOOR = 2'd1;
    localparam logic [1:0] RND_TRUNC = 2'd2;
    localparam logic [1:0] RND_NEAR  = 2'd3;

    localparam logic [63:0] K_M1 = 64'h5555555555555555;
    localparam logic [63:0] K_M2 = 64'h3333333333333333;
    localparam logic [63:0] K_M4 = 64'h0f0f0f0f0f0f0f0f;

    typedef struct packed {
        logic              is_sqrt;
        logic              dbl;
        logic [63:0]       res;
        logic [11:0]       exp_f;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [Q_W-1:0]    q;
    } t_cell;

    function automatic logic [6:0] f_clz64(logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    function automatic logic [6:0] f_ctz64(logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) n = 7'(i);
        end
        return n;
    endfunction

    function automatic logic [6:0] f_popcnt64(logic [63:0] x);
        logic [63:0] v;
        logic [6:0]  s;
        v = x - ((x >> 1) & K_M1);
        v = (v & K_M2) + ((v >> 2) & K_M2);
        v = (v + (v >> 4)) & K_M4;
        s = 7'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 7'(v[8*i +: 4]);
        end
        return s;
    endfunction

    // ceil / floor / trunc / nearest on a single or double bit pattern
    function automatic logic [63:0] f_integral(logic [63:0] x, logic dbl, logic [1:0] mode);
        int          mb;
        int          eb;
        int          u;
        logic [63:0] sbit;
        logic [63:0] mag;
        logic [63:0] fmask;
        logic [63:0] emax;
        logic [63:0] bias;
        logic [63:0] e;
        logic [63:0] mask;
        logic [63:0] f;
        logic [63:0] base;
        logic [63:0] half;
        logic [63:0] r;
        logic        neg;
        logic        up;
        mb    = dbl ? 52 : 23;
        eb    = dbl ? 11 : 8;
        sbit  = 64'd1 << (mb + eb);
        mag   = x & (sbit - 64'd1);
        fmask = (64'd1 << mb) - 64'd1;
        emax  = (64'd1 << eb) - 64'd1;
        bias  = emax >> 1;
        e     = mag >> mb;
        neg   = (x & sbit) != 64'd0;
        u     = int'(e[11:0]) - int'(bias[11:0]);
        up    = 1'b0;
        mask  = 64'd0;
        f     = 64'd0;
        base  = 64'd0;
        half  = 64'd0;
        if (e == emax) begin
            r = ((mag & fmask) != 64'd0) ? (x | (64'd1 << (mb - 1))) : x;
        end else if (mag == 64'd0) begin
            r = x;
        end else if (u < 0) begin
            half = (bias - 64'd1) << mb;
            case (mode)
                RND_CEIL:  up = !neg;
                RND_FLOOR: up = neg;
                RND_NEAR:  up = mag > half;
                default:   up = 1'b0;
            endcase
            r = (x & sbit) | (up ? (bias << mb) : 64'd0);
        end else if (u >= mb) begin
            r = x;
        end else begin
            mask = (64'd1 << (mb - u)) - 64'd1;
            f    = mag & mask;
            base = mag & ~mask;
            half = (mask + 64'd1) >> 1;
            case (mode)
                RND_CEIL:  up = !neg;
                RND_FLOOR: up = neg;
                RND_NEAR:  up = (f > half) || ((f == half) && mag[mb - u]);
                default:   up = 1'b0;
            endcase
            if (f == 64'd0) begin
                r = x;
            end else begin
                if (up) base = base + mask + 64'd1;
                r = (x & sbit) | base;
            end
        end
        return r;
    endfunction

endpackage

>>> design/wunu_if.sv
// ----------------------------------------------------------------------------
// wunu_in_if / wunu_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface wunu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  command;
    logic [63:0] operand;
    modport source (output valid, output command, output operand, input ready);
    modport sink   (input valid, input command, input operand, output ready);
endinterface

interface wunu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

>>> design/wasm_unary_numeric_unit.sv
// ----------------------------------------------------------------------------
// wasm_unary_numeric_unit
// WebAssembly unary numeric execute unit: clz/ctz/popcnt and float
// abs/neg/ceil/floor/trunc/nearest/sqrt on a 64-bit operand.
// ----------------------------------------------------------------------------
// the unit takes one command beat per cycle while the row is not held, and returns one
// result beat per command, in order: one decode stage, a row of 54 square-root cells
// (one root digit each, set by the 54 digits a double sqrt needs), and one rounding/
// output stage. every command walks the whole row so order is kept; when the output
// beat is not taken the whole row holds and i_cmd.ready drops, and it rises again in
// the cycle the result is taken.
// ----------------------------------------------------------------------------
module wasm_unary_numeric_unit import wunu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wunu_in_if.sink     i_cmd,
    wunu_out_if.source  o_res
);

    // whole row moves when the output register is free or being drained
    logic  adv;
    logic  out_valid;

    logic  vld [NUM_CELLS+1];
    t_cell cel [NUM_CELLS+1];

    assign adv         = !out_valid || o_res.ready;
    assign i_cmd.ready = adv;
    assign o_res.valid = out_valid;

    // decode, finish the easy ops, normalize the sqrt radicand
    wunu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_cmd.valid),
        .i_command (i_cmd.command),
        .i_operand (i_cmd.operand),
        .o_valid   (vld[0]),
        .o_cell    (cel[0])
    );

    // digit-recurrence row, one root bit per cell
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        wunu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (vld[g]),
            .i_cell  (cel[g]),
            .o_valid (vld[g+1]),
            .o_cell  (cel[g+1])
        );
    end

    // round the root to nearest even and pack, or pass the result decided up front
    wunu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (vld[NUM_CELLS]),
        .i_cell   (cel[NUM_CELLS]),
        .o_valid  (out_valid),
        .o_result (o_res.result)
    );

endmodule

>>> design/wunu_front.sv
// ----------------------------------------------------------------------------
// wunu_front
// Decode stage: integer ops, sign ops, rounding ops and sqrt special cases
// finish here; regular sqrt operands are normalized into a radicand.
// ----------------------------------------------------------------------------
module wunu_front import wunu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [4:0]  i_command,
    input  logic [63:0] i_operand,
    output logic        o_valid,
    output t_cell       o_cell
);

    logic        r_valid;
    t_cell       r_cell;
    t_cell       n_cell;

    logic        dbl;
    int          mb;
    int          eb;
    int          u;
    int          sh;
    logic [63:0] x;
    logic [63:0] lo;
    logic [63:0] sbit;
    logic [63:0] mag;
    logic [63:0] fmask;
    logic [63:0] emax;
    logic [63:0] bias;
    logic [63:0] e;
    logic [63:0] m;

    assign lo  = {32'd0, i_operand[31:0]};
    assign dbl = (i_command == CMD_F64_SQRT);

    always_comb begin
        mb    = dbl ? 52 : 23;
        eb    = dbl ? 11 : 8;
        x     = dbl ? i_operand : lo;
        sbit  = 64'd1 << (mb + eb);
        mag   = x & (sbit - 64'd1);
        fmask = (64'd1 << mb) - 64'd1;
        emax  = (64'd1 << eb) - 64'd1;
        bias  = emax >> 1;
        e     = mag >> mb;
        sh    = mb - (63 - int'(f_clz64(mag)));
        if (e == 64'd0) begin
            m = mag << sh;
            u = 1 - int'(bias[11:0]) - sh;
        end else begin
            m = (mag & fmask) | (64'd1 << mb);
            u = int'(e[11:0]) - int'(bias[11:0]);
        end
        if (u[0]) begin
            m = m << 1;
            u = u - 1;
        end

        n_cell       = '0;
        n_cell.dbl   = dbl;
        n_cell.exp_f = 12'(int'(bias[11:0]) + (u >>> 1) - 1);
        n_cell.rad   = dbl ? (RAD_W'(m) << 54) : (RAD_W'(m) << 25);
        unique case (i_command) inside
            CMD_I32_CLZ:    n_cell.res = 64'(f_clz64(lo)) - 64'd32;
            CMD_I32_CTZ:    n_cell.res = (lo == 64'd0) ? 64'd32 : 64'(f_ctz64(lo));
            CMD_I32_POPCNT: n_cell.res = 64'(f_popcnt64(lo));
            CMD_I64_CLZ:    n_cell.res = 64'(f_clz64(i_operand));
            CMD_I64_CTZ:    n_cell.res = 64'(f_ctz64(i_operand));
            CMD_I64_POPCNT: n_cell.res = 64'(f_popcnt64(i_operand));
            CMD_F32_ABS:    n_cell.res = lo & 64'h7fffffff;
            CMD_F32_NEG:    n_cell.res = lo ^ 64'h80000000;
            CMD_F32_CEIL, CMD_F32_FLOOR, CMD_F32_TRUNC, CMD_F32_NEAR:
                n_cell.res = f_integral(lo, 1'b0, 2'(i_command - CMD_F32_CEIL));
            CMD_F64_ABS:    n_cell.res = i_operand & 64'h7fffffffffffffff;
            CMD_F64_NEG:    n_cell.res = i_operand ^ 64'h8000000000000000;
            CMD_F64_CEIL, CMD_F64_FLOOR, CMD_F64_TRUNC, CMD_F64_NEAR:
                n_cell.res = f_integral(i_operand, 1'b1, 2'(i_command - CMD_F64_CEIL));
            CMD_F32_SQRT, CMD_F64_SQRT: begin
                if (e == emax && (mag & fmask) != 64'd0) begin
                    n_cell.res = x | (64'd1 << (mb - 1));
                end else if (mag == 64'd0) begin
                    n_cell.res = x;
                end else if ((x & sbit) != 64'd0) begin
                    n_cell.res = (emax << mb) | (64'd1 << (mb - 1));
                end else if (e == emax) begin
                    n_cell.res = x;
                end else begin
                    n_cell.is_sqrt = 1'b1;
                end
            end
            default:        n_cell.res = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

>>> design/wunu_cell.sv
// ----------------------------------------------------------------------------
// wunu_cell
// One root digit: shifts in a radicand bit pair, trial-subtracts, and hands
// partial root and remainder to the next cell.
// ----------------------------------------------------------------------------
module wunu_cell import wunu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic             r_valid;
    t_cell            r_cell;
    t_cell            n_cell;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;

    always_comb begin
        rem2   = {i_cell.rem[REM_W-3:0], i_cell.rad[RAD_W-1 -: 2]};
        trial  = REM_W'({i_cell.q, 2'b01});
        n_cell = i_cell;
        n_cell.rad = {i_cell.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            n_cell.rem = rem2 - trial;
            n_cell.q   = {i_cell.q[Q_W-2:0], 1'b1};
        end else begin
            n_cell.rem = rem2;
            n_cell.q   = {i_cell.q[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

>>> design/wunu_back.sv
// ----------------------------------------------------------------------------
// wunu_back
// Output register: rounds the finished root and packs it, or passes the
// result decided up front.
// ----------------------------------------------------------------------------
module wunu_back import wunu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_cell       i_cell,
    output logic        o_valid,
    output logic [63:0] o_result
);

    logic          r_valid;
    logic [63:0]   r_result;
    logic [63:0]   n_result;
    logic [Q_W-1:0] mant;

    always_comb begin
        mant = i_cell.q >> 1;
        if (i_cell.q[0] && (i_cell.rem != '0 || mant[0])) mant = mant + 1'b1;
        if (!i_cell.is_sqrt) begin
            n_result = i_cell.res;
        end else if (i_cell.dbl) begin
            n_result = ({52'd0, i_cell.exp_f} << 52) + 64'(mant);
        end else begin
            n_result = {32'd0, (32'(i_cell.exp_f[7:0]) << 23) + 32'(mant)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unary numeric unit: a directed table of corner
// cases, then random command beats, each result checked against a typed value or a predictor.
// ----------------------------------------------------------------------------
module testbench;
    import wunu_pkg::*;

    localparam logic [4:0] CMD_UNUSED   = 5'd25;
    localparam int         NUM_RANDOM   = 1930;
    localparam int         LATENCY      = 56;
    localparam int         LONG_HOLD    = 400;
    localparam int         IDLE_LIMIT   = 4000;

    typedef struct {
        logic [4:0]  cmd;
        logic [63:0] operand;
        bit          given;
        logic [63:0] value;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    wunu_in_if  cmd_ch ();
    wunu_out_if res_ch ();

    wasm_unary_numeric_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // typed expectation travels with the beat it belongs to
    bit          beat_given;
    logic [63:0] beat_value;

    logic [63:0] result_fifo[$];
    int          n_errors;
    int          n_taken;
    bit          stim_done;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] zeros_high(logic [63:0] v, int w);
        int n;
        n = w;
        while (v != 0) begin
            v = v >> 1;
            n--;
        end
        return 64'(n);
    endfunction

    function automatic logic [63:0] zeros_low(logic [63:0] v, int w);
        int n;
        n = 0;
        if (v == 0) return 64'(w);
        while (!v[0]) begin
            v = v >> 1;
            n++;
        end
        return 64'(n);
    endfunction

    function automatic logic [63:0] bits_set(logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) n += v[i];
        return 64'(n);
    endfunction

    function automatic logic [63:0] round_integral(logic [63:0] x, bit dbl, logic [1:0] mode);
        int          mb;
        int          eb;
        int          u;
        logic [63:0] sbit;
        logic [63:0] mag;
        logic [63:0] emax;
        logic [63:0] bias;
        logic [63:0] e;
        logic [63:0] mask;
        logic [63:0] frac;
        logic [63:0] kept;
        logic [63:0] half;
        bit          neg;
        bit          up;
        mb   = dbl ? 52 : 23;
        eb   = dbl ? 11 : 8;
        sbit = 64'd1 << (mb + eb);
        mag  = x & (sbit - 1);
        emax = (64'd1 << eb) - 1;
        bias = emax >> 1;
        e    = mag >> mb;
        neg  = (x & sbit) != 0;
        // nan gets its quiet bit, infinity passes
        if (e == emax) begin
            if ((mag & ((64'd1 << mb) - 1)) != 0) return x | (64'd1 << (mb - 1));
            return x;
        end
        if (mag == 0) return x;
        u = int'(e) - int'(bias);
        if (u < 0) begin
            // magnitude below one: result is signed zero or signed one
            case (mode)
                RND_CEIL:  up = !neg;
                RND_FLOOR: up = neg;
                RND_NEAR:  up = mag > ((bias - 1) << mb);
                default:   up = 0;
            endcase
            return (x & sbit) | (up ? (bias << mb) : 64'd0);
        end
        if (u >= mb) return x;
        mask = (64'd1 << (mb - u)) - 1;
        frac = mag & mask;
        kept = mag & ~mask;
        half = (mask + 1) >> 1;
        if (frac == 0) return x;
        case (mode)
            RND_CEIL:  up = !neg;
            RND_FLOOR: up = neg;
            RND_NEAR:  up = frac > half || (frac == half && mag[mb - u]);
            default:   up = 0;
        endcase
        if (up) kept = kept + mask + 1;
        return (x & sbit) | kept;
    endfunction

    function automatic logic [63:0] square_root(logic [63:0] x, bit dbl);
        int           mb;
        int           eb;
        int           u;
        logic [63:0]  sbit;
        logic [63:0]  mag;
        logic [63:0]  emax;
        logic [63:0]  bias;
        logic [63:0]  e;
        logic [63:0]  m;
        logic [63:0]  mant;
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] q;
        logic [127:0] t;
        mb   = dbl ? 52 : 23;
        eb   = dbl ? 11 : 8;
        sbit = 64'd1 << (mb + eb);
        mag  = x & (sbit - 1);
        emax = (64'd1 << eb) - 1;
        bias = emax >> 1;
        e    = mag >> mb;
        if (e == emax && (mag & ((64'd1 << mb) - 1)) != 0) return x | (64'd1 << (mb - 1));
        if (mag == 0) return x;
        // negative nonzero, -inf too: canonical nan
        if ((x & sbit) != 0) return (emax << mb) | (64'd1 << (mb - 1));
        if (e == emax) return x;
        if (e == 0) begin
            m = mag;
            u = 1 - int'(bias);
            while (m < (64'd1 << mb)) begin
                m = m << 1;
                u--;
            end
        end else begin
            m = (mag & ((64'd1 << mb) - 1)) | (64'd1 << mb);
            u = int'(e) - int'(bias);
        end
        if (u % 2 != 0) begin
            m = m << 1;
            u--;
        end
        // digit-by-digit root with one guard bit, then round to nearest even
        rad = 128'(m) << (mb + 2);
        rem = 0;
        q   = 0;
        for (int p = mb + 1; p >= 0; p--) begin
            rem = (rem << 2) | ((rad >> (2 * p)) & 128'd3);
            t   = (q << 2) | 128'd1;
            if (rem >= t) begin
                rem = rem - t;
                q   = (q << 1) | 128'd1;
            end else begin
                q = q << 1;
            end
        end
        mant = 64'(q >> 1);
        if (q[0] && (rem != 0 || mant[0])) mant++;
        return (64'(int'(bias) + u / 2 - 1) << mb) + mant;
    endfunction

    function automatic logic [63:0] predict_result(logic [4:0] cmd, logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] r;
        lo = {32'd0, v[31:0]};
        case (cmd)
            CMD_I32_CLZ:    r = zeros_high(lo, 32);
            CMD_I32_CTZ:    r = zeros_low(lo, 32);
            CMD_I32_POPCNT: r = bits_set(lo);
            CMD_I64_CLZ:    r = zeros_high(v, 64);
            CMD_I64_CTZ:    r = zeros_low(v, 64);
            CMD_I64_POPCNT: r = bits_set(v);
            CMD_F32_ABS:    r = lo & 64'h7fffffff;
            CMD_F32_NEG:    r = lo ^ 64'h80000000;
            CMD_F32_CEIL:   r = round_integral(lo, 0, RND_CEIL);
            CMD_F32_FLOOR:  r = round_integral(lo, 0, RND_FLOOR);
            CMD_F32_TRUNC:  r = round_integral(lo, 0, RND_TRUNC);
            CMD_F32_NEAR:   r = round_integral(lo, 0, RND_NEAR);
            CMD_F32_SQRT:   r = square_root(lo, 0);
            CMD_F64_ABS:    r = v & 64'h7fffffffffffffff;
            CMD_F64_NEG:    r = v ^ 64'h8000000000000000;
            CMD_F64_CEIL:   r = round_integral(v, 1, RND_CEIL);
            CMD_F64_FLOOR:  r = round_integral(v, 1, RND_FLOOR);
            CMD_F64_TRUNC:  r = round_integral(v, 1, RND_TRUNC);
            CMD_F64_NEAR:   r = round_integral(v, 1, RND_NEAR);
            CMD_F64_SQRT:   r = square_root(v, 1);
            default:        r = 64'd0;
        endcase
        if (cmd <= CMD_F32_SQRT) r[63:32] = 32'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table: value typed in only where it is obvious
    // ------------------------------------------------------------------------
    t_row directed[] = '{
        '{CMD_I32_CLZ,    64'h0,                 1, 64'd32},
        '{CMD_I32_CLZ,    64'hffffffff00000001,  1, 64'd31},
        '{CMD_I32_CTZ,    64'hffffffff00000000,  1, 64'd32},
        '{CMD_I32_POPCNT, 64'hffffffffffffffff,  1, 64'd32},
        '{CMD_I64_CLZ,    64'h0,                 1, 64'd64},
        '{CMD_I64_CTZ,    64'h0,                 1, 64'd64},
        '{CMD_I64_POPCNT, 64'hffffffffffffffff,  1, 64'd64},
        '{CMD_I64_CLZ,    64'h8000000000000000,  1, 64'd0},
        '{CMD_F32_ABS,    64'hffffffffffc00001,  1, 64'h7fc00001},
        '{CMD_F32_NEG,    64'h000000007f800000,  1, 64'hff800000},
        '{CMD_F32_CEIL,   64'h00000000bf000000,  1, 64'h80000000},
        '{CMD_F32_FLOOR,  64'h0000000000000001,  0, 64'h0},
        '{CMD_F32_TRUNC,  64'h00000000ff800000,  1, 64'hff800000},
        '{CMD_F32_NEAR,   64'h000000003fc00000,  1, 64'h40000000},
        '{CMD_F32_NEAR,   64'h000000007f800001,  1, 64'h7fc00001},
        '{CMD_F32_SQRT,   64'h00000000bf800000,  1, 64'h7fc00000},
        '{CMD_F32_SQRT,   64'h0000000040800000,  1, 64'h40000000},
        '{CMD_F32_SQRT,   64'h0000000080000000,  1, 64'h80000000},
        '{CMD_F32_SQRT,   64'h0000000000000001,  0, 64'h0},
        '{CMD_F64_ABS,    64'hfff0000000000000,  1, 64'h7ff0000000000000},
        '{CMD_F64_NEG,    64'h0000000000000000,  1, 64'h8000000000000000},
        '{CMD_F64_CEIL,   64'h7fefffffffffffff,  1, 64'h7fefffffffffffff},
        '{CMD_F64_FLOOR,  64'hbfe0000000000000,  1, 64'hbff0000000000000},
        '{CMD_F64_TRUNC,  64'h400c000000000000,  0, 64'h0},
        '{CMD_F64_NEAR,   64'h4004000000000000,  1, 64'h4000000000000000},
        '{CMD_F64_SQRT,   64'hfff0000000000000,  1, 64'h7ff8000000000000},
        '{CMD_F64_SQRT,   64'h7ff0000000000000,  1, 64'h7ff0000000000000},
        '{CMD_F64_SQRT,   64'h000fffffffffffff,  0, 64'h0},
        '{CMD_UNUSED,     64'hffffffffffffffff,  1, 64'h0}
    };

    // ------------------------------------------------------------------------
    // random operands, shaped toward the interesting float regions
    // ------------------------------------------------------------------------
    function automatic logic [63:0] pick_operand(logic [4:0] cmd);
        logic [63:0] v;
        bit          dbl;
        int          mb;
        int          eb;
        int          bias;
        int          u;
        v    = {$urandom, $urandom};
        dbl  = (cmd >= CMD_F64_ABS) || (cmd >= CMD_I64_CLZ && cmd <= CMD_I64_POPCNT);
        mb   = dbl ? 52 : 23;
        eb   = dbl ? 11 : 8;
        bias = (1 << (eb - 1)) - 1;
        case ($urandom_range(0, 5))
            0: ; // raw bits
            1: begin
                // near the integer boundary
                u = $urandom_range(0, mb + 3) - 3;
                v[mb +: 11] = 11'(bias + u);
                if (!dbl) v[31] = $urandom_range(0, 1);
            end
            2: begin
                // exact tie for nearest
                u = $urandom_range(0, mb - 1);
                v[mb +: 11] = 11'(bias + u);
                v = v & ~((64'd1 << (mb - u)) - 1);
                v = v | (64'd1 << (mb - u - 1));
                if (!dbl) v[31] = $urandom_range(0, 1);
            end
            3: begin
                // zero or max exponent, often with an empty fraction
                v[mb +: 11] = $urandom_range(0, 1) ? 11'(0) : 11'((1 << eb) - 1);
                if (!dbl) v[31] = $urandom_range(0, 1);
                if ($urandom_range(0, 1)) v = v & ~((64'd1 << mb) - 1);
            end
            4: v = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            default: v = v >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // command sender
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [4:0] cmd, logic [63:0] operand, bit given,
                             logic [63:0] value);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.operand <= operand;
        beat_given     <= given;
        beat_value     <= value;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    initial begin
        logic [4:0] cmd;
        stim_done      = 0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_I32_CLZ;
        cmd_ch.operand <= 64'd0;
        beat_given     <= 1'b0;
        beat_value     <= 64'd0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        foreach (directed[i])
            send_beat(directed[i].cmd, directed[i].operand, directed[i].given,
                      directed[i].value);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            // mostly defined commands, a few unused codes
            cmd = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(20, 31))
                                                : 5'($urandom_range(0, 19));
            send_beat(cmd, pick_operand(cmd), 1'b0, 64'd0);
        end
        cmd_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // ------------------------------------------------------------------------
    // result receiver, with one long hold-off to back the unit up
    // ------------------------------------------------------------------------
    initial begin
        int  stall;
        bit  held;
        held = 0;
        res_ch.ready <= 1'b0;
        forever begin
            stall = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (!held && n_taken > 600) begin
                held  = 1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: queue an expectation on each command beat, check on each result beat
    // ------------------------------------------------------------------------
    initial begin
        int          idle;
        logic [63:0] want;
        n_errors = 0;
        n_taken  = 0;
        idle     = 0;
        forever begin
            @(posedge i_clk);
            idle++;
            if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
                idle = 0;
                result_fifo.push_back(beat_given ? beat_value
                                      : predict_result(cmd_ch.command, cmd_ch.operand));
            end
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                idle = 0;
                n_taken++;
                if (result_fifo.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result %h", $time, res_ch.result);
                end else begin
                    want = result_fifo.pop_front();
                    if (res_ch.result !== want) begin
                        n_errors++;
                        $display("%0t: result expected %h actual %h", $time, want,
                                 res_ch.result);
                    end
                end
            end
            if (idle >= IDLE_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------------
    initial begin
        wait (stim_done);
        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_errors == 0 && result_fifo.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
design/wunu_pkg.sv
design/wunu_if.sv
design/wunu_front.sv
design/wunu_cell.sv
design/wunu_back.sv
design/wasm_unary_numeric_unit.sv
verif/testbench.sv
